[hw/rtl/ard_pkg.sv]
// Shared types, codes and decode functions of the asynchronous receive packet deframer.
package ard_pkg;

    // Parser phases.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_BODY    = 2'd1;
    localparam logic [1:0] PH_TRAILER = 2'd2;
    localparam logic [1:0] PH_DROP    = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_GARBAGE = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    // Transaction codes that need special handling.
    localparam logic [3:0] TC_BLOCK_WRITE_REQ  = 4'd1;
    localparam logic [3:0] TC_WRITE_RESP       = 4'd2;
    localparam logic [3:0] TC_QUAD_READ_RESP   = 4'd6;
    localparam logic [3:0] TC_BLOCK_READ_RESP  = 4'd7;
    localparam logic [3:0] TC_LOCK_REQ         = 4'd9;
    localparam logic [3:0] TC_STREAM           = 4'd10;
    localparam logic [3:0] TC_LOCK_RESP        = 4'd11;

    localparam logic [31:0] PAD_QUADLET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  tcode;
        logic [15:0] packet_offset;
        logic [4:0]  header_bytes;
        logic [15:0] data_bytes;
        logic [16:0] total_bytes;
        logic        rcode_valid;
        logic [3:0]  rcode;
        logic        has_trailer;
        logic [15:0] xfer_status;
        logic [15:0] time_stamp;
    } ard_result_t;

    // Header length in bytes per tcode; zero marks a tcode the parser does not know.
    function automatic logic [4:0] hdr_len(input logic [3:0] tc);
        logic [4:0] len;
        unique case (tc)
            4'd2, 4'd4, 4'd13, 4'd14: len = 5'd12;
            4'd10:                    len = 5'd8;
            4'd3, 4'd12, 4'd15:       len = 5'd0;
            default:                  len = 5'd16;
        endcase
        return len;
    endfunction

    function automatic logic is_resp(input logic [3:0] tc);
        return (tc == TC_WRITE_RESP) || (tc == TC_QUAD_READ_RESP) ||
               (tc == TC_BLOCK_READ_RESP) || (tc == TC_LOCK_RESP);
    endfunction

    function automatic logic is_block(input logic [3:0] tc);
        return (tc == TC_BLOCK_WRITE_REQ) || (tc == TC_BLOCK_READ_RESP) ||
               (tc == TC_LOCK_REQ) || (tc == TC_LOCK_RESP);
    endfunction

endpackage

[hw/rtl/ard_parser.sv]
// Packet parser state and the single-pass decode of one quadlet into the next state and a result.
module ard_parser #(
    parameter int BUFFER_BYTES = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [31:0]        quadlet,
    input  logic               end_of_buffer,
    output logic               res_fire,
    output ard_pkg::ard_result_t res
);
    import ard_pkg::*;

    localparam int PW = $clog2(BUFFER_BYTES + 1);
    localparam logic [31:0] SAT_LIM = (BUFFER_BYTES > 131071) ? 32'd131071 : 32'(BUFFER_BYTES);

    logic [1:0]    phase_reg, phase_next;
    logic [3:0]    tcode_reg, tcode_next;
    logic          hw0_zero_reg, hw0_zero_next;
    logic          hw1_zero_reg, hw1_zero_next;
    logic [3:0]    rcode_reg, rcode_next;
    logic [14:0]   qip_reg, qip_next;
    logic [15:0]   plen_reg, plen_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] pad_reg, pad_next;
    logic [PW-1:0] start_reg, start_next;

    logic          eob;
    logic [4:0]    hb_q;
    logic [4:0]    hb_s;
    logic [16:0]   len_sum;
    logic [16:0]   aligned;
    logic          with_rc;
    logic          trailer;
    logic [1:0]    status;
    logic [31:0]   total32;
    logic [31:0]   start32;
    logic          resp;

    // The buffer also ends where the next quadlet would no longer fit.
    assign eob  = end_of_buffer || ((32'(pos_reg) + 32'd8) > 32'(BUFFER_BYTES));
    assign hb_q = hdr_len(quadlet[7:4]);
    assign hb_s = hdr_len(tcode_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        tcode_next    = tcode_reg;
        hw0_zero_next = hw0_zero_reg;
        hw1_zero_next = hw1_zero_reg;
        rcode_next    = rcode_reg;
        qip_next      = qip_reg;
        plen_next     = plen_reg;
        pad_next      = pad_reg;
        start_next    = start_reg;
        res_fire      = 1'b0;
        with_rc       = 1'b0;
        trailer       = 1'b0;
        status        = ST_OK;
        total32       = 32'd0;
        len_sum       = 17'd0;
        aligned       = 17'd0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (quadlet == PAD_QUADLET)
                begin
                    pad_next = pad_reg + PW'(4);
                end
                else
                begin
                    tcode_next    = quadlet[7:4];
                    hw0_zero_next = (quadlet == 32'd0);
                    hw1_zero_next = 1'b1;
                    rcode_next    = 4'd0;
                    start_next    = pos_reg;
                    plen_next     = 16'd0;
                    qip_next      = 15'd1;
                    total32       = 32'(pad_reg) + 32'd4;
                    if (eob)
                    begin
                        res_fire = 1'b1;
                        status   = ST_TRUNC;
                    end
                    else if (hb_q == 5'd0)
                    begin
                        res_fire   = 1'b1;
                        status     = ST_UNKNOWN;
                        pad_next   = '0;
                        phase_next = PH_DROP;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                qip_next = qip_reg + 15'd1;
                if (qip_next == 15'd2)
                begin
                    hw1_zero_next = (quadlet == 32'd0);
                    rcode_next    = quadlet[15:12];
                end
                if (((tcode_reg == TC_STREAM) && (qip_next == 15'd2)) ||
                    (is_block(tcode_reg) && (qip_next == 15'd4)))
                begin
                    plen_next = quadlet[31:16];
                end
                len_sum = 17'(hb_s) + 17'(plen_next) + 17'd3;
                aligned = {len_sum[16:2], 2'b00};
                if (qip_next >= len_sum[16:2])
                begin
                    if (eob)
                    begin
                        res_fire = 1'b1;
                        with_rc  = 1'b1;
                        total32  = 32'(pad_reg) + 32'(aligned);
                        status   = (hw0_zero_reg && hw1_zero_next) ? ST_GARBAGE : ST_OK;
                        pad_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_TRAILER;
                    end
                end
                else if (eob)
                begin
                    res_fire = 1'b1;
                    status   = ST_TRUNC;
                    total32  = 32'(pad_reg) + {15'd0, qip_next, 2'b00};
                end
            end
            PH_TRAILER:
            begin
                len_sum  = 17'(hb_s) + 17'(plen_reg) + 17'd3;
                aligned  = {len_sum[16:2], 2'b00};
                res_fire = 1'b1;
                with_rc  = 1'b1;
                trailer  = 1'b1;
                total32  = 32'(pad_reg) + 32'(aligned) + 32'd4;
                pad_next = '0;
                if (hw0_zero_reg && hw1_zero_reg && (quadlet == 32'd0))
                begin
                    status     = ST_GARBAGE;
                    phase_next = PH_DROP;
                end
                else
                begin
                    status     = ST_OK;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_DROP;
            end
        endcase

        if (eob)
        begin
            phase_next = PH_IDLE;
            pos_next   = '0;
            pad_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + PW'(4);
        end
    end

    assign resp    = is_resp(tcode_next);
    assign start32 = 32'(start_next);

    always_comb
    begin
        res.status        = status;
        res.tcode         = tcode_next;
        res.packet_offset = start32[15:0];
        res.header_bytes  = hdr_len(tcode_next);
        res.data_bytes    = plen_next;
        res.total_bytes   = (total32 > SAT_LIM) ? SAT_LIM[16:0] : total32[16:0];
        res.rcode_valid   = with_rc && resp;
        res.rcode         = (with_rc && resp) ? rcode_next : 4'd0;
        res.has_trailer   = trailer;
        res.xfer_status   = trailer ? quadlet[31:16] : 16'd0;
        res.time_stamp    = trailer ? quadlet[15:0] : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tcode_reg    <= 4'd0;
            hw0_zero_reg <= 1'b1;
            hw1_zero_reg <= 1'b1;
            rcode_reg    <= 4'd0;
            qip_reg      <= 15'd0;
            plen_reg     <= 16'd0;
            pos_reg      <= '0;
            pad_reg      <= '0;
            start_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tcode_reg    <= tcode_next;
            hw0_zero_reg <= hw0_zero_next;
            hw1_zero_reg <= hw1_zero_next;
            rcode_reg    <= rcode_next;
            qip_reg      <= qip_next;
            plen_reg     <= plen_next;
            pos_reg      <= pos_next;
            pad_reg      <= pad_next;
            start_reg    <= start_next;
        end
    end

endmodule

[hw/rtl/async_receive_packet_deframer_unit.sv]
// Top level of the asynchronous receive packet deframer: input register, parser, result register.
//
// Receive-buffer quadlets enter on the s_ stream, one item per quadlet, with s_tlast on the
// last quadlet of a buffer. Each completed, rejected or truncated packet leaves as one item
// on the m_ stream: m_tuser carries the status code and m_tdata the decoded packet fields.
// Padding quadlets and quadlets dropped after a rejection produce no item.
// An accepted quadlet waits in the input register until the decode may proceed, is decoded
// at that edge, and a result is shown on m_tvalid the cycle after the edge that decodes it.
// The block takes one quadlet every cycle while no result is stalled on m_tready; the rate is
// set by the single decode pass between the input register and the result register.
// Reset empties both registers, returns the parser to waiting for a packet start and sets
// the buffer position to zero.
// While m_tready is low a waiting result holds, the decode stalls, and after one more
// quadlet has entered the input register s_tready falls until the result is taken.
module async_receive_packet_deframer_unit #(
    parameter int BUFFER_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // quadlet[31:0]
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    // tcode[3:0], packet_offset[19:4], header_bytes[24:20], data_bytes[40:25],
    // total_bytes[57:41], rcode_valid[58], rcode[62:59], has_trailer[63],
    // xfer_status[79:64], time_stamp[95:80]
    output logic [95:0] m_tdata,
    output logic [1:0]  m_tuser    // status[1:0]
);
    import ard_pkg::*;

    logic        in_valid_reg;
    logic [31:0] in_data_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    ard_result_t out_res_reg;
    logic        proc;
    logic        res_fire;
    ard_result_t res;

    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    ard_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (proc),
        .quadlet      (in_data_reg),
        .end_of_buffer(in_last_reg),
        .res_fire     (res_fire),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc && res_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc && res_fire)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {out_res_reg.time_stamp, out_res_reg.xfer_status,
                       out_res_reg.has_trailer, out_res_reg.rcode, out_res_reg.rcode_valid,
                       out_res_reg.total_bytes, out_res_reg.data_bytes,
                       out_res_reg.header_bytes, out_res_reg.packet_offset,
                       out_res_reg.tcode};

endmodule

[hw/rtl/ard_checker.sv]
// Port-level checks of the deframer's result stream, bound to the top level.
module ard_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import ard_pkg::*;

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // An unknown tcode always reports a zero header length.
    a_unknown_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_UNKNOWN) |-> (m_tdata[24:20] == 5'd0))
        else $error("unknown tcode with nonzero header length");

    // Rejected and truncated packets carry no rcode and no trailer.
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == ST_UNKNOWN) || (m_tuser == ST_TRUNC)) |->
        !m_tdata[58] && !m_tdata[63])
        else $error("rejected packet carries rcode or trailer");

    // The rcode is zero whenever it is not valid.
    a_rcode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[58] |-> (m_tdata[62:59] == 4'd0))
        else $error("rcode set without rcode_valid");

    // Trailer fields are zero without a trailer.
    a_trailer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[63] |-> (m_tdata[95:64] == 32'd0))
        else $error("trailer fields set without a trailer");

endmodule

bind async_receive_packet_deframer_unit ard_checker u_ard_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
